>>> rtl/ile_pkg.sv
// Package for the indexed list engine: sizes, operation codes, the per-cell
// command type and the controller state type.
// No dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package ile_pkg;

  // List size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream beats.
  localparam int FUNC_W   = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int IN_W     = FUNC_W + POS_W + DATA_W;
  localparam int OUT_W    = STAT_W + DATA_W + COUNT_W + 1;
  localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // Width used when comparing a request index against the fill level.
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Request codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 4'd0,
    FN_PUSH_BACK  = 4'd1,
    FN_POP_FRONT  = 4'd2,
    FN_POP_BACK   = 4'd3,
    FN_INSERT     = 4'd4,
    FN_ERASE      = 4'd5,
    FN_READ_AT    = 4'd6,
    FN_WRITE_AT   = 4'd7,
    FN_READ_FRONT = 4'd8,
    FN_READ_BACK  = 4'd9,
    FN_CLEAR      = 4'd10
  } func_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // What every cell does in one cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE,
    CELL_READ
  } cell_op_t;

  // Command broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  data;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

>>> rtl/ile_cell.sv
// One storage cell of the list: holds one element and one stage of the
// read-out chain that carries a read value down toward cell zero.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_cell
  import ile_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  idx,        // fixed place of this cell in the row
  input  logic [DATA_W-1:0] prev_elem,  // element of the cell below
  input  logic [DATA_W-1:0] next_elem,  // element of the cell above
  input  logic [DATA_W-1:0] rd_in,      // read chain from the cell above
  output logic [DATA_W-1:0] elem,
  output logic [DATA_W-1:0] rd_out
);

  logic [DATA_W-1:0] elem_next;
  logic [DATA_W-1:0] rd_next;

  // Element update: shift up on insert, down on erase, load on write.
  always_comb begin
    elem_next = elem;
    case (cmd.op)
      CELL_INSERT: begin
        if (idx > cmd.pos) begin
          elem_next = prev_elem;
        end else if (idx == cmd.pos) begin
          elem_next = cmd.data;
        end
      end
      CELL_ERASE: begin
        if (idx >= cmd.pos) begin
          elem_next = next_elem;
        end
      end
      CELL_WRITE: begin
        if (idx == cmd.pos) begin
          elem_next = cmd.data;
        end
      end
      default: begin
        elem_next = elem;
      end
    endcase
  end

  // Read chain: the addressed cell loads its element, all others load zero;
  // in every other cycle the chain moves one cell down.
  always_comb begin
    if (cmd.op == CELL_READ) begin
      rd_next = (idx == cmd.pos) ? elem : '0;
    end else begin
      rd_next = rd_in;
    end
  end

  always_ff @(posedge clk) begin
    elem   <= elem_next;
    rd_out <= rd_next;
  end

endmodule

>>> rtl/ile_ctrl.sv
// Controller of the indexed list engine: decodes request beats, keeps the
// fill level, drives the cell row and holds the result register.
// Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_ctrl
  import ile_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Request side
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [POS_W-1:0]    position,
  input  logic [DATA_W-1:0]   data_in,
  // Result side
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [STAT_W-1:0]   status,
  output logic [DATA_W-1:0]   read_value,
  output logic [COUNT_W-1:0]  count,
  output logic                is_empty,
  // Cell row
  output cell_cmd_t           cmd,
  input  logic [DATA_W-1:0]   rd0
);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   fill;
  logic [IDX_W-1:0]   rd_cnt;
  logic               accept;
  logic               read_done;

  // Decoded request
  status_t            dec_status;
  logic [CNT_W-1:0]   dec_fill;
  cell_cmd_t          dec_cmd;
  logic               dec_read;
  logic [CMP_W-1:0]   pos_x;
  logic [CMP_W-1:0]   fill_x;
  logic               full;
  logic               empty;

  assign pos_x  = CMP_W'(position);
  assign fill_x = CMP_W'(fill);
  assign full   = (fill == CNT_W'(CAPACITY));
  assign empty  = (fill == '0);

  // Request decode against the current fill level.
  always_comb begin
    dec_status   = STAT_OK;
    dec_fill     = fill;
    dec_read     = 1'b0;
    dec_cmd.op   = CELL_HOLD;
    dec_cmd.pos  = '0;
    dec_cmd.data = data_in;
    unique case (func_t'(func))
      FN_PUSH_FRONT: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_cmd.op = CELL_INSERT;
          dec_fill   = fill + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_cmd.op  = CELL_WRITE;
          dec_cmd.pos = IDX_W'(fill);
          dec_fill    = fill + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (!empty) begin
          dec_cmd.op = CELL_ERASE;
          dec_fill   = fill - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (!empty) begin
          dec_fill = fill - 1'b1;
        end
      end
      FN_INSERT: begin
        if (pos_x > fill_x) begin
          dec_status = STAT_RANGE;
        end else if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_cmd.op  = CELL_INSERT;
          dec_cmd.pos = IDX_W'(position);
          dec_fill    = fill + 1'b1;
        end
      end
      FN_ERASE: begin
        if (pos_x >= fill_x) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_cmd.op  = CELL_ERASE;
          dec_cmd.pos = IDX_W'(position);
          dec_fill    = fill - 1'b1;
        end
      end
      FN_READ_AT: begin
        if (pos_x >= fill_x) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_cmd.op  = CELL_READ;
          dec_cmd.pos = IDX_W'(position);
          dec_read    = 1'b1;
        end
      end
      FN_WRITE_AT: begin
        if (pos_x >= fill_x) begin
          dec_status = STAT_RANGE;
        end else begin
          dec_cmd.op  = CELL_WRITE;
          dec_cmd.pos = IDX_W'(position);
        end
      end
      FN_READ_FRONT: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_cmd.op = CELL_READ;
          dec_read   = 1'b1;
        end
      end
      FN_READ_BACK: begin
        if (empty) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_cmd.op  = CELL_READ;
          dec_cmd.pos = IDX_W'(fill - 1'b1);
          dec_read    = 1'b1;
        end
      end
      FN_CLEAR: begin
        dec_fill = '0;
      end
      default: begin
        dec_fill = fill;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && dec_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs: take a beat only when idle and the result slot frees up.
  always_comb begin
    s_tready  = 1'b0;
    read_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
      end
      ST_READ: begin
        read_done = (rd_cnt == '0);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Cells only act on the cycle a beat is accepted.
  always_comb begin
    cmd = dec_cmd;
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill <= dec_fill;
      end
      if ((accept && !dec_read) || read_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Read countdown: the value reaches cell zero after pos shifts.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cnt <= dec_cmd.pos;
    end else if (state == ST_READ && rd_cnt != '0) begin
      rd_cnt <= rd_cnt - 1'b1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && !dec_read) begin
      status     <= dec_status;
      read_value <= '0;
      count      <= COUNT_W'(dec_fill);
      is_empty   <= (dec_fill == '0);
    end else if (read_done) begin
      status     <= STAT_OK;
      read_value <= rd0;
      count      <= COUNT_W'(fill);
      is_empty   <= (fill == '0);
    end
  end

endmodule

>>> rtl/indexed_list_engine.sv
// Indexed list engine: ordered list of signed 32-bit values in a row of cells.
// Results are registered; a successful read first walks its value down the read
// chain to cell zero, one cell per shift, before its result is registered.
// Throughput: one request at a time; a new beat is taken once the previous
// result has been taken or is taken in the same cycle.
// Reset (rst, synchronous) empties the list; element contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_engine
  import ile_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_BYTES_W-1:0]  s_tdata,   // func[3:0], position[10:4], data_in[42:11]
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_BYTES_W-1:0] m_tdata    // status[1:0], read_value[33:2],
                                            // count[40:34], is_empty[41]
);

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] elem_q [CAPACITY];
  logic [DATA_W-1:0] rd_q   [CAPACITY];
  logic [STAT_W-1:0]  status;
  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] count;
  logic               is_empty;

  // Controller and result register.
  ile_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .func       (s_tdata[FUNC_W-1:0]),
    .position   (s_tdata[FUNC_W+POS_W-1:FUNC_W]),
    .data_in    (s_tdata[IN_W-1:FUNC_W+POS_W]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .status     (status),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .cmd        (cmd),
    .rd0        (rd_q[0])
  );

  // Row of cells; the end cells see themselves as missing neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_elem;
    logic [DATA_W-1:0] next_elem;
    logic [DATA_W-1:0] rd_in;

    if (i == 0) begin : g_first
      assign prev_elem = elem_q[i];
    end else begin : g_mid_lo
      assign prev_elem = elem_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_elem = elem_q[i];
      assign rd_in     = '0;
    end else begin : g_mid_hi
      assign next_elem = elem_q[i+1];
      assign rd_in     = rd_q[i+1];
    end

    ile_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (IDX_W'(i)),
      .prev_elem (prev_elem),
      .next_elem (next_elem),
      .rd_in     (rd_in),
      .elem      (elem_q[i]),
      .rd_out    (rd_q[i])
    );
  end

  // Pack the result beat, zero padded to whole bytes.
  assign m_tdata = OUT_BYTES_W'({is_empty, count, read_value, status});

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for indexed_list_engine: a directed table and random
// request traffic, checked beat by beat against a list model kept in the bench.
// Depends on rtl/ile_pkg.sv and rtl/indexed_list_engine.sv.
`timescale 1ns / 1ps

module tb_top;
  import ile_pkg::*;

  // Run shape.
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_RANDOM    = 1375;
  localparam int SEGMENT_LEN   = 125;
  localparam int QUIET_ITEMS   = 150;
  localparam int PRESSURE_AT   = 400;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = CAPACITY + 16;
  localparam int MAX_PRINTED   = 40;

  // Function codes the block treats as no operation.
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd11;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  // Extreme data values.
  localparam logic [DATA_W-1:0] DATA_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] DATA_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] DATA_ONES = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0]  POS_TOP   = 7'd127;

  // Traffic mixes of the random segments.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_BALANCE,
    MIX_SHRINK
  } mix_t;

  // One result of the list.
  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } list_result_t;

  // One row of the directed table; typed marks a hand-written expectation.
  typedef struct packed {
    logic [FUNC_W-1:0]   fn;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   value;
    logic                typed;
    list_result_t        want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
    // Reads, pops, erase, write and an out-of-range insert on an empty list after reset.
    '{FN_READ_FRONT, 7'd0,  32'd0,      1'b1, '{STAT_EMPTY, 32'd0, 7'd0, 1'b1}},
    '{FN_READ_BACK,  7'd0,  32'd0,      1'b1, '{STAT_EMPTY, 32'd0, 7'd0, 1'b1}},
    '{FN_POP_FRONT,  7'd0,  32'd0,      1'b1, '{STAT_OK,    32'd0, 7'd0, 1'b1}},
    '{FN_POP_BACK,   7'd0,  32'd0,      1'b1, '{STAT_OK,    32'd0, 7'd0, 1'b1}},
    '{FN_ERASE,      7'd0,  32'd0,      1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
    '{FN_READ_AT,    7'd0,  32'd0,      1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
    '{FN_WRITE_AT,   7'd0,  32'd5,      1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
    '{FN_INSERT,     7'd1,  32'd9,      1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
    // Build a short list from the extremes.
    '{FN_INSERT,     7'd0,  DATA_MAX,   1'b1, '{STAT_OK,    32'd0, 7'd1, 1'b0}},
    '{FN_PUSH_FRONT, 7'd0,  DATA_MIN,   1'b1, '{STAT_OK,    32'd0, 7'd2, 1'b0}},
    '{FN_PUSH_BACK,  7'd0,  DATA_ONES,  1'b1, '{STAT_OK,    32'd0, 7'd3, 1'b0}},
    '{FN_READ_FRONT, 7'd0,  32'd0,      1'b1, '{STAT_OK,    DATA_MIN,  7'd3, 1'b0}},
    '{FN_READ_BACK,  7'd0,  32'd0,      1'b1, '{STAT_OK,    DATA_ONES, 7'd3, 1'b0}},
    '{FN_READ_AT,    7'd1,  32'd0,      1'b1, '{STAT_OK,    DATA_MAX,  7'd3, 1'b0}},
    '{FN_WRITE_AT,   7'd2,  32'd0,      1'b1, '{STAT_OK,    32'd0, 7'd3, 1'b0}},
    // Insert at the end and in the middle, erase the head.
    '{FN_INSERT,     7'd3,  32'h1234_5678, 1'b0, '0},
    '{FN_INSERT,     7'd1,  32'hA5A5_A5A5, 1'b0, '0},
    '{FN_ERASE,      7'd0,  32'd0,      1'b0, '0},
    '{FN_READ_AT,    7'd3,  32'd0,      1'b0, '0},
    // Indexes far past the end, and unused codes.
    '{FN_READ_AT,    POS_TOP, 32'd0,    1'b1, '{STAT_RANGE, 32'd0, 7'd4, 1'b0}},
    '{FN_ERASE,      POS_TOP, 32'd0,    1'b1, '{STAT_RANGE, 32'd0, 7'd4, 1'b0}},
    '{FN_UNUSED_LO,  7'd0,  32'd0,      1'b1, '{STAT_OK,    32'd0, 7'd4, 1'b0}},
    '{FN_UNUSED_HI,  POS_TOP, DATA_ONES, 1'b1, '{STAT_OK,   32'd0, 7'd4, 1'b0}},
    '{FN_READ_BACK,  7'd0,  32'd0,      1'b0, '0},
    '{FN_CLEAR,      7'd0,  32'd0,      1'b1, '{STAT_OK,    32'd0, 7'd0, 1'b1}}
  };

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_BYTES_W-1:0]   s_tdata;   // func[3:0], position[10:4], data_in[42:11]
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_BYTES_W-1:0]  m_tdata;   // status[1:0], read_value[33:2],
                                      // count[40:34], is_empty[41]

  // List model state.
  logic [DATA_W-1:0]       list_cells [CAPACITY];
  int                      list_fill;
  list_result_t            pending_results [$];

  // Run control and statistics.
  int                      mismatches;
  int                      requests_sent;
  int                      results_seen;
  int                      fill_peak;
  int                      status_seen [4];
  int                      gap_pct;
  int                      stall_pct;
  bit                      quiet_tail;
  bit                      long_hold_done;

  indexed_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Long limit on the whole run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t ns: mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
  endtask

  // Applies one request to the list model and returns the result it gives.
  function automatic list_result_t predict_request(logic [FUNC_W-1:0] fn,
                                                   logic [POS_W-1:0] pos,
                                                   logic [DATA_W-1:0] value);
    list_result_t res;
    int at;
    at = int'(pos);
    res = '0;
    res.status = STAT_OK;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
        if (fn == FN_PUSH_FRONT) at = 0;
        else if (fn == FN_PUSH_BACK) at = list_fill;
        // The index check comes before the full check.
        if (at > list_fill) res.status = STAT_RANGE;
        else if (list_fill >= CAPACITY) res.status = STAT_FULL;
        else begin
          for (int i = list_fill; i > at; i--) list_cells[i] = list_cells[i-1];
          list_cells[at] = value;
          list_fill++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_ERASE: begin
        if (fn == FN_POP_FRONT) at = 0;
        else if (fn == FN_POP_BACK) at = list_fill - 1;
        // A pop on an empty list is dropped without any error.
        if (fn == FN_ERASE || list_fill != 0) begin
          if (at >= list_fill) res.status = STAT_RANGE;
          else begin
            for (int i = at; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
            list_fill--;
          end
        end
      end
      FN_READ_AT, FN_READ_FRONT, FN_READ_BACK: begin
        if (fn == FN_READ_FRONT) at = 0;
        else if (fn == FN_READ_BACK) at = list_fill - 1;
        if (fn != FN_READ_AT && list_fill == 0) res.status = STAT_EMPTY;
        else if (at >= list_fill) res.status = STAT_RANGE;
        else res.read_value = list_cells[at];
      end
      FN_WRITE_AT: begin
        if (at >= list_fill) res.status = STAT_RANGE;
        else list_cells[at] = value;
      end
      FN_CLEAR: list_fill = 0;
      default: ;
    endcase
    res.count    = list_fill[COUNT_W-1:0];
    res.is_empty = (list_fill == 0);
    return res;
  endfunction

  // Offers one request beat, waits for it to be taken and records the
  // result it should give. Returns at the next falling edge.
  task automatic offer_request(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] value, input bit typed,
                               input list_result_t typed_want);
    logic [IN_BYTES_W-1:0] beat;
    list_result_t predicted;
    beat = '0;
    beat[0 +: FUNC_W]             = fn;
    beat[FUNC_W +: POS_W]         = pos;
    beat[FUNC_W + POS_W +: DATA_W] = value;
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    predicted = predict_request(fn, pos, value);
    pending_results.push_back(typed ? typed_want : predicted);
    if (list_fill > fill_peak) fill_peak = list_fill;
    requests_sent++;
    @(negedge clk);
  endtask

  // Random gap on the request side; none in the quiet tail.
  task automatic maybe_pause_sender();
    if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  // Picks a function code for the given traffic mix.
  function automatic logic [FUNC_W-1:0] pick_func(mix_t mix);
    func_t grow_ops [3];
    func_t shrink_ops [3];
    func_t access_ops [4];
    int grow_pct;
    int shrink_pct;
    int roll;
    grow_ops   = '{FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT};
    shrink_ops = '{FN_POP_FRONT, FN_POP_BACK, FN_ERASE};
    access_ops = '{FN_READ_AT, FN_WRITE_AT, FN_READ_FRONT, FN_READ_BACK};
    case (mix)
      MIX_GROW:   begin grow_pct = 60; shrink_pct = 10; end
      MIX_SHRINK: begin grow_pct = 10; shrink_pct = 60; end
      default:    begin grow_pct = 32; shrink_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) return grow_ops[$urandom_range(0, 2)];
    if (roll < grow_pct + shrink_pct) return shrink_ops[$urandom_range(0, 2)];
    if (roll < 97) return access_ops[$urandom_range(0, 3)];
    // Clear and the unused codes.
    return FUNC_W'($urandom_range(FN_CLEAR, FN_UNUSED_HI));
  endfunction

  // Picks an index: mostly valid, often at the edges, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_pos();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return POS_W'($urandom_range(0, list_fill));
    if (roll < 75) return POS_W'((list_fill == 0) ? 0 : list_fill - 1);
    if (roll < 82) return POS_W'(list_fill);
    return POS_W'($urandom_range(0, POS_TOP));
  endfunction

  // Picks a data word, with the extremes now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] corners [4];
    corners = '{32'd0, DATA_ONES, DATA_MIN, DATA_MAX};
    if ($urandom_range(0, 99) < 15) return corners[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Request side: reset, directed table, random segments, then the end.
  initial begin
    mix_t mix;
    int seg;
    int in_seg;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    list_fill      = 0;
    mismatches     = 0;
    requests_sent  = 0;
    fill_peak      = 0;
    gap_pct        = 25;
    stall_pct      = 8;
    quiet_tail     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      maybe_pause_sender();
      offer_request(DIR_ROWS[r].fn, DIR_ROWS[r].pos, DIR_ROWS[r].value,
                    DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // Random segments; each has its own mix and its own amount of idling.
    seg = 0;
    in_seg = 0;
    mix = MIX_GROW;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (in_seg == 0) begin
        mix       = mix_t'(seg % 3);
        gap_pct   = (seg % 4 == 1) ? 0 : 10 + 15 * (seg % 3);
        stall_pct = (seg % 4 == 2) ? 0 : 4 + 4 * (seg % 3);
        seg++;
      end
      in_seg = (in_seg + 1) % SEGMENT_LEN;
      if (n >= NUM_RANDOM - QUIET_ITEMS) quiet_tail = 1'b1;
      maybe_pause_sender();
      offer_request(pick_func(mix), pick_pos(), pick_value(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // Drain, then give a slow read time to show anything extra.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results left over", pending_results.size(), 0);

    $display("Sent %0d requests (%0d from the table) and took %0d results; peak fill %0d of %0d.",
             requests_sent, NUM_DIRECTED, results_seen, fill_peak, CAPACITY);
    $display("Statuses seen: ok %0d, range %0d, empty %0d, full %0d; mismatches %0d.",
             status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_EMPTY],
             status_seen[STAT_FULL], mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and the check of each beat.
  initial begin
    list_result_t want;
    status_t got_status;
    logic [DATA_W-1:0] got_value;
    logic [COUNT_W-1:0] got_count;
    logic got_empty;
    int stall_left;
    int hold_left;
    m_tready       = 1'b0;
    results_seen   = 0;
    long_hold_done = 1'b0;
    stall_left     = 0;
    hold_left      = 0;
    status_seen    = '{default: 0};
    forever begin
      @(negedge clk);
      if (hold_left > 0) hold_left--;
      else if (!long_hold_done && results_seen >= PRESSURE_AT) begin
        // Hold off long enough that the block has to stop taking requests.
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else if (stall_left > 0) stall_left--;
      else if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 17);
      m_tready <= !rst && hold_left == 0 && stall_left == 0;

      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got_status = status_t'(m_tdata[0 +: STAT_W]);
        got_value  = m_tdata[STAT_W +: DATA_W];
        got_count  = m_tdata[STAT_W + DATA_W +: COUNT_W];
        got_empty  = m_tdata[STAT_W + DATA_W + COUNT_W];
        results_seen++;
        status_seen[got_status]++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", got_value, 0);
        end else begin
          want = pending_results.pop_front();
          if (got_status != want.status)
            report_mismatch("status", got_status, want.status);
          if (got_value != want.read_value)
            report_mismatch("read_value", got_value, want.read_value);
          if (got_count != want.count)
            report_mismatch("count", got_count, want.count);
          if (got_empty != want.is_empty)
            report_mismatch("is_empty", got_empty, want.is_empty);
        end
      end
    end
  end

endmodule
